@@ rtl/v3alu_pkg.sv @@
package v3alu_pkg;

  typedef enum logic [2:0] {
    K_ADD   = 3'd0,
    K_SUB   = 3'd1,
    K_SCALE = 3'd2,
    K_MUL   = 3'd3,
    K_DOT   = 3'd4,
    K_CROSS = 3'd5,
    K_LEN   = 3'd6,
    K_NORM  = 3'd7
  } kind_t;

  typedef logic signed [31:0] q_t;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Sideband that travels alongside the arithmetic through every stage.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] sc;
    logic        flag;
    logic [31:0] len;
  } side_t;

  // Rounds an exact Q32.32 value to Q16.16, ties towards plus infinity,
  // then clamps to 32 bits. The top bit of the result is the clamp flag.
  function automatic logic [32:0] rnd_sat(input logic signed [65:0] v);
    logic signed [66:0] t;
    logic signed [50:0] h;
    logic [32:0]        res;
    t = 67'(v) + 67'sd32768;
    h = t[66:16];
    if (h > 51'sd2147483647) begin
      res = {1'b1, Q_MAX};
    end else if (h < -51'sd2147483648) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, h[31:0]};
    end
    return res;
  endfunction

  function automatic logic [32:0] sat33(input logic signed [32:0] v);
    logic [32:0] res;
    if (v > 33'sd2147483647) begin
      res = {1'b1, Q_MAX};
    end else if (v < -33'sd2147483648) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

@@ rtl/v3alu_lane.sv @@
module v3alu_lane
  import v3alu_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         en,
  input  kind_t              kind,
  input  logic signed [31:0] ai,
  input  logic signed [31:0] aj,
  input  logic signed [31:0] ak,
  input  logic signed [31:0] bi,
  input  logic signed [31:0] bj,
  input  logic signed [31:0] bk,
  input  logic signed [31:0] f,
  output logic signed [63:0] prod,
  output logic [31:0]        r,
  output logic               sat
);

  kind_t              kind0_r, kind1_r;
  logic signed [63:0] p0_r, p1_r, p0_nxt, p1_nxt;
  logic signed [32:0] as_r, as_nxt;
  logic signed [65:0] v1_r, v1_nxt;
  logic [31:0]        r_r;
  logic               sat_r;
  logic [32:0]        res_nxt;
  logic signed [31:0] op_a, op_b;

  // Stage 0: operand selection and the two lane multipliers.
  always_comb begin
    op_a = (kind == K_CROSS) ? aj : ai;
    case (kind)
      K_SCALE: op_b = f;
      K_MUL:   op_b = bi;
      K_DOT:   op_b = bi;
      K_CROSS: op_b = bk;
      default: op_b = ai;
    endcase
    p0_nxt = op_a * op_b;
    p1_nxt = ak * bj;
    as_nxt = (kind == K_SUB) ? (33'(ai) - 33'(bi)) : (33'(ai) + 33'(bi));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kind0_r <= kind;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      as_r    <= as_nxt;
    end
  end

  // Stage 1: the cross product difference is formed exactly; other kinds pass their value on.
  always_comb begin
    if (kind0_r inside {K_ADD, K_SUB}) begin
      v1_nxt = 66'(as_r);
    end else if (kind0_r == K_CROSS) begin
      v1_nxt = 66'(p0_r) - 66'(p1_r);
    end else begin
      v1_nxt = 66'(p0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      kind1_r <= kind0_r;
      v1_r    <= v1_nxt;
    end
  end

  // Stage 2: rounding and clamping of the lane result.
  always_comb begin
    case (kind1_r)
      K_ADD:   res_nxt = sat33(v1_r[32:0]);
      K_SUB:   res_nxt = sat33(v1_r[32:0]);
      K_SCALE: res_nxt = rnd_sat(v1_r);
      K_MUL:   res_nxt = rnd_sat(v1_r);
      K_CROSS: res_nxt = rnd_sat(v1_r);
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r_r   <= res_nxt[31:0];
      sat_r <= res_nxt[32];
    end
  end

  assign prod = p0_r;
  assign r    = r_r;
  assign sat  = sat_r;

endmodule

@@ rtl/v3alu_sqrt.sv @@
module v3alu_sqrt
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] en,
  input  logic [63:0] s,
  output logic [31:0] root,
  output logic [33:0] rem
);

  logic [33:0] rem_r  [32];
  logic [31:0] root_r [32];
  logic [63:0] sh_r   [32];
  logic [33:0] rem_in [32];
  logic [31:0] root_in[32];
  logic [63:0] sh_in  [32];

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar j = 0; j < 32; j++) begin : g_step
    logic [35:0] cur, trial, diff;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in[j]  = '0;
      assign root_in[j] = '0;
      assign sh_in[j]   = s;
    end else begin : g_next
      assign rem_in[j]  = rem_r[j-1];
      assign root_in[j] = root_r[j-1];
      assign sh_in[j]   = sh_r[j-1];
    end

    assign cur   = {rem_in[j], sh_in[j][63:62]};
    assign trial = {2'b00, root_in[j], 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j]  <= ge ? diff[33:0] : cur[33:0];
        root_r[j] <= {root_in[j][30:0], ge};
        sh_r[j]   <= {sh_in[j][61:0], 2'b00};
      end
    end
  end

  assign root = root_r[31];
  assign rem  = rem_r[31];

endmodule

@@ rtl/v3alu_div.sv @@
module v3alu_div
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic [17:0] en,
  input  logic [31:0] m,
  input  logic [31:0] len,
  output logic [16:0] q
);

  logic [31:0] rem_r [18];
  logic [16:0] nl_r  [18];
  logic [16:0] q_r   [18];
  logic [31:0] d_r   [18];
  logic [47:0] n_nxt;

  // Prep stage: numerator with the half-divisor rounding term added.
  assign n_nxt = {m, 16'h0000} + {17'h0, len[31:1]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= {1'b0, n_nxt[47:17]};
      nl_r[0]  <= n_nxt[16:0];
      q_r[0]   <= '0;
      d_r[0]   <= len;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k < 18; k++) begin : g_step
    logic [32:0] cur, diff;
    logic        ge;

    assign cur  = {rem_r[k-1], nl_r[k-1][16]};
    assign ge   = (cur >= {1'b0, d_r[k-1]});
    assign diff = cur - {1'b0, d_r[k-1]};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? diff[31:0] : cur[31:0];
        nl_r[k]  <= {nl_r[k-1][15:0], 1'b0};
        q_r[k]   <= {q_r[k-1][15:0], ge};
        d_r[k]   <= d_r[k-1];
      end
    end
  end

  assign q = q_r[17];

endmodule

@@ rtl/vec3_alu.sv @@
// Throughput: one item per cycle while out_ready is high; the depth is set by the 32-stage
// square root followed by the 18-stage dividers used for the unit vector.
// Each stage holds when the next one is full and stalled, so bubbles close up.
// Reset (synchronous, active low) clears only the stage valid bits.
module vec3_alu
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_ax,
  input  logic [31:0] in_ay,
  input  logic [31:0] in_az,
  input  logic [31:0] in_bx,
  input  logic [31:0] in_by,
  input  logic [31:0] in_bz,
  input  logic [31:0] in_factor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rx,
  output logic [31:0] out_ry,
  output logic [31:0] out_rz,
  output logic [31:0] out_scalar_out,
  output logic        out_saturated
);

  localparam int NST    = 54;
  localparam int SQ0    = 2;
  localparam int LEN_ST = 34;
  localparam int DV0    = 35;
  localparam int OUT_ST = 53;

  logic [NST-1:0]     v_r, v_nxt, en;
  side_t              side_r   [OUT_ST];
  side_t              side_nxt [OUT_ST];
  logic signed [31:0] ina [3];
  logic signed [31:0] inb [3];
  logic signed [63:0] prod [3];
  logic [31:0]        lr [3];
  logic [2:0]         ls;
  logic signed [65:0] s1_r, s1_nxt;
  logic [32:0]        dot_r;
  logic [31:0]        sq_root;
  logic [33:0]        sq_rem;
  logic [31:0]        len_nxt;
  logic [31:0]        dm [3];
  logic [16:0]        dq [3];
  logic [31:0]        nr [3];
  logic [31:0]        rx_r, ry_r, rz_r, sc_r;
  logic               flag_r;

  // Stage enables: a stage may load when it is empty or its successor moves.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];

  assign ina[0] = in_ax;
  assign ina[1] = in_ay;
  assign ina[2] = in_az;
  assign inb[0] = in_bx;
  assign inb[1] = in_by;
  assign inb[2] = in_bz;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3alu_lane u_lane (
      .clk  (clk),
      .en   (en[2:0]),
      .kind (kind_t'(in_kind)),
      .ai   (ina[i]),
      .aj   (ina[J]),
      .ak   (ina[K]),
      .bi   (inb[i]),
      .bj   (inb[J]),
      .bk   (inb[K]),
      .f    (in_factor),
      .prod (prod[i]),
      .r    (lr[i]),
      .sat  (ls[i])
    );
  end

  // Merge: the exact sum of the three lane products serves both the dot
  // product and the squared length.
  assign s1_nxt = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r <= s1_nxt;
    end
    if (en[2]) begin
      dot_r <= rnd_sat(s1_r);
    end
  end

  v3alu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[SQ0+31:SQ0]),
    .s    (s1_r[63:0]),
    .root (sq_root),
    .rem  (sq_rem)
  );

  // Round the square root to nearest: the remainder exceeds the root only
  // when the true root lies above the half-way point.
  assign len_nxt = sq_root + {31'h0, (sq_rem > {2'b00, sq_root})};

  always_comb begin
    side_nxt[0]      = '0;
    side_nxt[0].kind = kind_t'(in_kind);
    side_nxt[0].ax   = in_ax;
    side_nxt[0].ay   = in_ay;
    side_nxt[0].az   = in_az;
    for (int k = 1; k < OUT_ST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[3].rx   = lr[0];
    side_nxt[3].ry   = lr[1];
    side_nxt[3].rz   = lr[2];
    side_nxt[3].sc   = (side_r[2].kind == K_DOT) ? dot_r[31:0] : '0;
    side_nxt[3].flag = (|ls) || ((side_r[2].kind == K_DOT) && dot_r[32]);
    side_nxt[LEN_ST].len = len_nxt;
    if (side_r[LEN_ST-1].kind == K_LEN) begin
      side_nxt[LEN_ST].sc   = (len_nxt > Q_MAX) ? Q_MAX : len_nxt;
      side_nxt[LEN_ST].flag = (len_nxt > Q_MAX);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < OUT_ST; k++) begin
      if (en[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign dm[0] = side_r[LEN_ST].ax[31] ? (~side_r[LEN_ST].ax + 32'd1) : side_r[LEN_ST].ax;
  assign dm[1] = side_r[LEN_ST].ay[31] ? (~side_r[LEN_ST].ay + 32'd1) : side_r[LEN_ST].ay;
  assign dm[2] = side_r[LEN_ST].az[31] ? (~side_r[LEN_ST].az + 32'd1) : side_r[LEN_ST].az;

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div u_div (
      .clk (clk),
      .en  (en[DV0+17:DV0]),
      .m   (dm[i]),
      .len (side_r[LEN_ST].len),
      .q   (dq[i])
    );
  end

  // Unit vector components take the sign of the original component.
  assign nr[0] = side_r[OUT_ST-1].ax[31] ? (32'd0 - {15'h0, dq[0]}) : {15'h0, dq[0]};
  assign nr[1] = side_r[OUT_ST-1].ay[31] ? (32'd0 - {15'h0, dq[1]}) : {15'h0, dq[1]};
  assign nr[2] = side_r[OUT_ST-1].az[31] ? (32'd0 - {15'h0, dq[2]}) : {15'h0, dq[2]};

  always_ff @(posedge clk) begin
    if (en[OUT_ST]) begin
      if (side_r[OUT_ST-1].kind == K_NORM) begin
        if (side_r[OUT_ST-1].len == '0) begin
          rx_r <= '0;
          ry_r <= '0;
          rz_r <= '0;
        end else begin
          rx_r <= nr[0];
          ry_r <= nr[1];
          rz_r <= nr[2];
        end
      end else begin
        rx_r <= side_r[OUT_ST-1].rx;
        ry_r <= side_r[OUT_ST-1].ry;
        rz_r <= side_r[OUT_ST-1].rz;
      end
      sc_r   <= side_r[OUT_ST-1].sc;
      flag_r <= side_r[OUT_ST-1].flag;
    end
  end

  assign out_valid      = v_r[OUT_ST];
  assign out_rx         = rx_r;
  assign out_ry         = ry_r;
  assign out_rz         = rz_r;
  assign out_scalar_out = sc_r;
  assign out_saturated  = flag_r;

  // A raised flag means at least one delivered value sits at a range end.
  a_sat_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rx == Q_MAX || out_rx == Q_MIN || out_ry == Q_MAX || out_ry == Q_MIN ||
       out_rz == Q_MAX || out_rz == Q_MIN ||
       out_scalar_out == Q_MAX || out_scalar_out == Q_MIN))
    else $error("saturated flag without a clamped value");

  // The square root remainder never exceeds twice the root.
  a_sqrt_rem : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[SQ0+31] |-> (sq_rem <= {1'b0, sq_root, 1'b0}))
    else $error("square root remainder out of bound");

  // A unit vector component never exceeds one.
  a_unit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[OUT_ST-1] && side_r[OUT_ST-1].kind == K_NORM && side_r[OUT_ST-1].len != '0) |->
      (dq[0] <= 17'd65536 && dq[1] <= 17'd65536 && dq[2] <= 17'd65536))
    else $error("unit vector quotient above one");

endmodule

@@ dv/vec3_alu_tb.sv @@
module vec3_alu_tb
  import v3alu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1300;
  localparam int CALM_TAIL  = 200;
  localparam int DRAIN_WAIT = 80;

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] sc;
    logic        sat;
  } vres_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] ax, ay, az, bx, by, bz, factor;
    logic        typed;
    vres_t       want;
  } vop_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [31:0] in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_factor;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_rx, out_ry, out_rz, out_scalar_out;
  logic        out_saturated;

  vres_t pending_q[$];
  vop_t  directed[$];
  int    n_err;
  bit    calm;

  vec3_alu DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("vec3_alu test failed");
    $finish;
  end

  function automatic logic [31:0] clamp_q(input logic signed [66:0] v, inout logic flag);
    if (v > 67'sd2147483647) begin
      flag = 1'b1;
      return Q_MAX;
    end else if (v < -67'sd2147483648) begin
      flag = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Q32.32 to Q16.16, to nearest with ties towards plus infinity.
  function automatic logic signed [66:0] to_q16(input logic signed [66:0] v);
    return (v + 67'sd32768) >>> 16;
  endfunction

  function automatic logic signed [66:0] prod(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [66:0] wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Integer square root, rounded to nearest.
  function automatic longint unsigned root_near(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (s > res) res++;
    return res;
  endfunction

  function automatic logic [31:0] unit_comp(input logic signed [31:0] a,
                                            input longint unsigned len);
    longint signed   a64;
    longint unsigned m, q;
    a64 = a;
    m = (a64 < 0) ? longint'(-a64) : longint'(a64);
    q = ((m << 16) + (len >> 1)) / len;
    return (a64 < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic vres_t vec_predict(input vop_t op);
    vres_t r;
    logic signed [31:0] a[3], b[3];
    logic signed [66:0] w[3];
    longint unsigned    sq, len;
    logic               fl;
    r = '{default: '0};
    fl = 1'b0;
    a = '{op.ax, op.ay, op.az};
    b = '{op.bx, op.by, op.bz};
    case (op.kind)
      K_ADD, K_SUB: begin
        for (int i = 0; i < 3; i++) begin
          w[i] = (op.kind == K_ADD) ? 67'(a[i]) + 67'(b[i]) : 67'(a[i]) - 67'(b[i]);
          w[i] = 67'(clamp_q(w[i], fl));
        end
      end
      K_SCALE: for (int i = 0; i < 3; i++)
        w[i] = 67'(clamp_q(to_q16(prod(a[i], op.factor)), fl));
      K_MUL: for (int i = 0; i < 3; i++)
        w[i] = 67'(clamp_q(to_q16(prod(a[i], b[i])), fl));
      K_DOT: begin
        r.sc = clamp_q(to_q16(prod(a[0], b[0]) + prod(a[1], b[1]) + prod(a[2], b[2])), fl);
        w = '{default: '0};
      end
      K_CROSS: for (int i = 0; i < 3; i++)
        w[i] = 67'(clamp_q(to_q16(prod(a[(i+1)%3], b[(i+2)%3])
                                  - prod(a[(i+2)%3], b[(i+1)%3])), fl));
      default: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq += 64'(prod(a[i], a[i]));
        len = root_near(sq);
        w = '{default: '0};
        if (op.kind == K_LEN) begin
          r.sc = clamp_q(67'(len), fl);
        end else if (len != 0) begin
          for (int i = 0; i < 3; i++) w[i] = 67'(unit_comp(a[i], len));
        end
      end
    endcase
    r.rx = w[0][31:0];
    r.ry = w[1][31:0];
    r.rz = w[2][31:0];
    r.sat = fl;
    return r;
  endfunction

  function automatic vop_t mk(input kind_t k, input logic [31:0] ax, ay, az, bx, by, bz,
                              f, input logic typed = 1'b0,
                              input logic [31:0] rx = 0, ry = 0, rz = 0, sc = 0,
                              input logic sat = 1'b0);
    vop_t op;
    op = '{k, ax, ay, az, bx, by, bz, f, typed, '{rx, ry, rz, sc, sat}};
    return op;
  endfunction

  // Operand mix: full-range words, small magnitudes around unity, randomly shifted-down words and the range ends.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      3: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      4: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'h0;
          3: return 32'h0001_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic vop_t rand_op();
    return mk(kind_t'($urandom_range(0, 7)), rand_q(), rand_q(), rand_q(),
              rand_q(), rand_q(), rand_q(), rand_q());
  endfunction

  task automatic send_op(input vop_t op);
    in_valid  <= 1'b1;
    in_kind   <= op.kind;
    in_ax     <= op.ax;
    in_ay     <= op.ay;
    in_az     <= op.az;
    in_bx     <= op.bx;
    in_by     <= op.by;
    in_bz     <= op.bz;
    in_factor <= op.factor;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(op.typed ? op.want : vec_predict(op));
  endtask

  // Result side: compare every transfer with the oldest outstanding expectation.
  always @(posedge clk) begin
    vres_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        w = pending_q.pop_front();
        if (out_rx !== w.rx || out_ry !== w.ry || out_rz !== w.rz ||
            out_scalar_out !== w.sc || out_saturated !== w.sat) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch at %0t: want %h %h %h sc %h sat %b, got %h %h %h sc %h sat %b",
                     $realtime, w.rx, w.ry, w.rz, w.sc, w.sat,
                     out_rx, out_ry, out_rz, out_scalar_out, out_saturated);
        end
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    vop_t op;
    int   wait_cyc;
    n_err = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= K_ADD;
    {in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_factor} <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(K_ADD, Q_MAX, 1, 0, 1, Q_MIN, 5, 0, 1, Q_MAX, Q_MIN + 1, 5, 0, 1));
    directed.push_back(mk(K_SUB, Q_MIN, 0, Q_MAX, 1, 0, Q_MIN, 0, 1, Q_MIN, 0, Q_MAX, 0, 1));
    directed.push_back(mk(K_SUB, 7, 7, 7, 7, 7, 7, 0, 1));
    directed.push_back(mk(K_SCALE, 32'h0001_0000, 32'hffff_0000, 3, 9, 9, 9, 32'h0001_0000,
                          1, 32'h0001_0000, 32'hffff_0000, 3, 0, 0));
    directed.push_back(mk(K_SCALE, Q_MAX, Q_MIN, 32'h8000, 0, 0, 0, 32'h0000_8000));
    directed.push_back(mk(K_SCALE, 1, 32'hffff_ffff, 3, 0, 0, 0, 32'h0000_8000));
    directed.push_back(mk(K_MUL, Q_MIN, Q_MAX, 0, Q_MIN, Q_MIN, Q_MAX, 0,
                          1, Q_MAX, Q_MIN, 0, 0, 1));
    directed.push_back(mk(K_MUL, 32'h0002_8000, 32'hfffe_0000, 5, 32'h0003_0000,
                          32'h0000_4000, 32'h0000_8000, Q_MAX));
    directed.push_back(mk(K_DOT, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 1));
    directed.push_back(mk(K_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0,
                          1, 0, 0, 0, Q_MAX, 1));
    directed.push_back(mk(K_DOT, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
                          32'h0004_0000, 32'h0000_8000, 32'h0001_0000, 0));
    directed.push_back(mk(K_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0,
                          1, 0, 0, 32'h0001_0000, 0, 0));
    directed.push_back(mk(K_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0));
    directed.push_back(mk(K_LEN, 0, 0, 0, 5, 5, 5, 5, 1));
    directed.push_back(mk(K_LEN, 32'hfffd_0000, 0, 32'h0004_0000, Q_MAX, 0, 0, 0,
                          1, 0, 0, 0, 32'h0005_0000, 0));
    directed.push_back(mk(K_LEN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 1, 0, 0, 0, Q_MAX, 1));
    directed.push_back(mk(K_LEN, 1, 1, 1, 0, 0, 0, 0));
    directed.push_back(mk(K_NORM, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1));
    directed.push_back(mk(K_NORM, Q_MIN, 0, 0, 0, 0, 0, 0, 1, 32'hffff_0000, 0, 0, 0, 0));
    directed.push_back(mk(K_NORM, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0));
    directed.push_back(mk(K_NORM, 1, 0, 0, 0, 0, 0, 0, 1, 32'h0001_0000, 0, 0, 0, 0));
    directed.push_back(mk(K_NORM, 1, 1, 32'hffff_ffff, 0, 0, 0, 0));

    foreach (directed[i]) send_op(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - CALM_TAIL) calm = 1'b1;
      // Hold the sender back once until the pipeline has fully drained.
      if (n == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      op = rand_op();
      send_op(op);
    end
    in_valid <= 1'b0;

    wait_cyc = 0;
    while (pending_q.size() != 0 && wait_cyc < 100_000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("vec3_alu test passed");
    end else begin
      $display("vec3_alu test failed");
    end
    $finish;
  end

endmodule

@@ vec3_alu.f @@
rtl/v3alu_pkg.sv
rtl/v3alu_lane.sv
rtl/v3alu_sqrt.sv
rtl/v3alu_div.sv
rtl/vec3_alu.sv
dv/vec3_alu_tb.sv
